>>> src/mml_pkg.sv
// Package for the MML note event parser: payload structs, parser state codes,
// command codes, frequency table and shared constants. No dependencies.
`default_nettype none
package mml_pkg;

  localparam int unsigned MaxEventsDef = 256;
  localparam int unsigned NumLimit     = 100000;
  localparam int unsigned DivBits      = 29;   // 360000000 and tempo*length fit in 29 bits

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
  } mml_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [21:0] frequency_q8;
    logic [23:0] duration_us;
    logic [13:0] gap_us;
    logic [3:0]  volume;
    logic        end_of_track;
  } mml_out_t;

  typedef enum logic [1:0] {
    KIND_NOTE  = 2'd0,
    KIND_REST  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } mml_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_CMD    = 2'd1,
    MODE_LETTER = 2'd2,
    MODE_LEN    = 2'd3
  } mml_mode_t;

  typedef enum logic [1:0] {
    CMD_O = 2'd0,
    CMD_L = 2'd1,
    CMD_T = 2'd2,
    CMD_V = 2'd3
  } mml_cmd_t;

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'd0,
    SEQ_PARSE = 3'd1,
    SEQ_MUL   = 3'd2,
    SEQ_DIV   = 3'd3,
    SEQ_GAP   = 3'd4,
    SEQ_OUT   = 3'd5
  } mml_seq_t;

  // request from sequencer to the divider
  typedef struct packed {
    logic               start;
    logic [DivBits-1:0] dividend;
    logic [DivBits-1:0] divisor;
  } mml_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DivBits-1:0] quotient;
  } mml_div_rsp_t;

  // octave-9 frequencies in Q16, C9..B9
  function automatic logic [29:0] freq_o9(input logic [3:0] idx);
    logic [29:0] f;
    case (idx)
      4'd0:    f = 30'd548668578;
      4'd1:    f = 30'd581294109;
      4'd2:    f = 30'd615859655;
      4'd3:    f = 30'd652480576;
      4'd4:    f = 30'd691279090;
      4'd5:    f = 30'd732384684;
      4'd6:    f = 30'd775934544;
      4'd7:    f = 30'd822074013;
      4'd8:    f = 30'd870957077;
      4'd9:    f = 30'd922746880;
      4'd10:   f = 30'd977616265;
      4'd11:   f = 30'd1035748353;
      default: f = 30'd0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

>>> src/mml_note_event_parser.sv
// Top level of the MML note event parser: character parser, event sequencer
// and output register. Depends on mml_pkg and mml_div.
//
//  channel | ports                         | direction
//  in      | in_valid, in_ready, in_data   | characters and end of string
//  out     | out_valid, out_ready, out_data| note, rest, error, end events
//  cfg     | cfg_we, cfg_wdata             | default volume write
//
// A character that forms no event goes from parsing back to idle. An event
// that needs a duration is parsed while tempo times length is formed, then
// the divider is started and delivers 29 quotient bits and a done flag, the
// 15% gap step runs and the result register is loaded. Errors and end markers
// go from parsing straight to the load. Synchronous reset returns to the
// string start state. in_ready is low while an item is in work; a finished
// event waits in its last state while the result register is still full.
`default_nettype none
module mml_note_event_parser #(
  parameter int unsigned MAX_EVENTS = mml_pkg::MaxEventsDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mml_pkg::mml_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mml_pkg::mml_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [3:0]       cfg_wdata
);
  import mml_pkg::*;

  localparam int EcW = $clog2(MAX_EVENTS + 1);

  // parser state
  mml_mode_t   mode_r, mode_nxt;
  mml_cmd_t    cmd_r, cmd_nxt;
  logic [3:0]  oct_r, oct_nxt;
  logic [6:0]  dlen_r, dlen_nxt;
  logic [7:0]  tempo_r, tempo_nxt;
  logic [3:0]  vol_r, vol_nxt;
  logic [3:0]  dvol_r;
  logic [4:0]  semi_r, semi_nxt;
  logic        rest_r, rest_nxt;
  logic [19:0] acc_r, acc_nxt;
  logic        dig_r, dig_nxt;
  logic [EcW-1:0] ec_r, ec_nxt;
  logic        ovf_r, ovf_nxt;

  // sequencer
  mml_seq_t    seq_r, seq_nxt;
  mml_in_t     item_r;
  logic        dot_r, dot_nxt;
  logic        eot_r, eot_nxt;
  mml_kind_t   kind_r, kind_nxt;
  logic [27:0] prod_r, prod_nxt;
  logic [23:0] dur_r, dur_nxt;
  logic [13:0] gap_r, gap_nxt;
  logic [21:0] frq_r, frq_nxt;
  logic        ov_r;
  mml_out_t    ov_data_r, res_data;
  logic        res_load;

  mml_div_req_t dreq;
  mml_div_rsp_t drsp;

  mml_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  dval;
  logic [19:0] acc_dig;
  logic        is_acc;
  logic        note_end;
  logic [19:0] len;
  logic [6:0]  n7;
  logic [12:0] n_mul;
  logic [3:0]  n_q;
  logic [3:0]  n_oct, n_idx;
  logic [4:0]  shamt;
  logic [29:0] ftab;
  logic [27:0] dur15;
  logic [40:0] gprod;
  logic [13:0] gapq;

  assign in_ready = (seq_r == SEQ_IDLE);

  // character decode
  always_comb begin
    c = item_r.ch;
    if (c >= 8'h61 && c <= 8'h7a) c = c - 8'd32;
    is_digit = (item_r.ch >= 8'h30 && item_r.ch <= 8'h39);
    dval     = item_r.ch[3:0];
    acc_dig  = (acc_r < 20'(NumLimit)) ? 20'(acc_r * 20'd10 + 20'(dval)) : acc_r;
    is_acc   = (mode_r == MODE_LETTER) && !rest_r &&
               (item_r.ch == 8'h23 || item_r.ch == 8'h2b || item_r.ch == 8'h2d);
  end

  // parser step, run once per accepted item in SEQ_PARSE, plus trailing-character and end-of-string handling in SEQ_OUT
  always_comb begin
    mode_nxt  = mode_r;  cmd_nxt = cmd_r;  oct_nxt = oct_r;  dlen_nxt = dlen_r;
    tempo_nxt = tempo_r; vol_nxt = vol_r;  semi_nxt = semi_r; rest_nxt = rest_r;
    acc_nxt   = acc_r;   dig_nxt = dig_r;  ec_nxt = ec_r;    ovf_nxt = ovf_r;
    dot_nxt   = dot_r;   eot_nxt = eot_r;  note_end = 1'b0;  kind_nxt = kind_r;
    if (seq_r == SEQ_PARSE) begin
      eot_nxt  = item_r.func;
      dot_nxt  = 1'b0;
      kind_nxt = KIND_END;
      if (item_r.func) begin
        if (!ovf_r && (mode_r == MODE_LETTER || mode_r == MODE_LEN)) begin
          note_end = 1'b1;
        end else if (!ovf_r && mode_r == MODE_CMD && dig_r) begin
          case (cmd_r)
            CMD_O: if (acc_r >= 20'd1 && acc_r <= 20'd8) oct_nxt = acc_r[3:0];
            CMD_L: if (acc_r >= 20'd1 && acc_r <= 20'd64) dlen_nxt = acc_r[6:0];
            CMD_T: if (acc_r >= 20'd32 && acc_r <= 20'd255) tempo_nxt = acc_r[7:0];
            default: vol_nxt = (acc_r > 20'd15) ? 4'd15 : acc_r[3:0];
          endcase
        end
      end else if (!ovf_r) begin
        if (mode_r == MODE_CMD && is_digit) begin
          acc_nxt = acc_dig;
          dig_nxt = 1'b1;
        end else if ((mode_r == MODE_LETTER || mode_r == MODE_LEN) && (is_acc || is_digit))
        begin
          if (is_acc) semi_nxt = (item_r.ch == 8'h2d) ? semi_r - 5'd1 : semi_r + 5'd1;
          else begin
            acc_nxt = acc_dig;
            dig_nxt = 1'b1;
          end
          mode_nxt = MODE_LEN;
        end else if (mode_r == MODE_LETTER || mode_r == MODE_LEN) begin
          note_end = 1'b1;
          dot_nxt  = (item_r.ch == 8'h2e);
        end else begin
          // command close, then idle handling of this character
          if (mode_r == MODE_CMD && dig_r) begin
            case (cmd_r)
              CMD_O: if (acc_r >= 20'd1 && acc_r <= 20'd8) oct_nxt = acc_r[3:0];
              CMD_L: if (acc_r >= 20'd1 && acc_r <= 20'd64) dlen_nxt = acc_r[6:0];
              CMD_T: if (acc_r >= 20'd32 && acc_r <= 20'd255) tempo_nxt = acc_r[7:0];
              default: vol_nxt = (acc_r > 20'd15) ? 4'd15 : acc_r[3:0];
            endcase
          end
          mode_nxt = MODE_IDLE;
          case (c)
            8'h4f, 8'h4c, 8'h54, 8'h56: begin
              cmd_nxt  = (c == 8'h4f) ? CMD_O : (c == 8'h4c) ? CMD_L :
                         (c == 8'h54) ? CMD_T : CMD_V;
              acc_nxt  = '0;
              dig_nxt  = 1'b0;
              mode_nxt = MODE_CMD;
            end
            8'h3e: if (oct_nxt < 4'd8) oct_nxt = oct_nxt + 4'd1;
            8'h3c: if (oct_nxt > 4'd1) oct_nxt = oct_nxt - 4'd1;
            8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h52: begin
              rest_nxt = (c == 8'h52);
              case (c)
                8'h41:   semi_nxt = 5'd10;
                8'h42:   semi_nxt = 5'd12;
                8'h43:   semi_nxt = 5'd1;
                8'h44:   semi_nxt = 5'd3;
                8'h45:   semi_nxt = 5'd5;
                8'h46:   semi_nxt = 5'd6;
                8'h47:   semi_nxt = 5'd8;
                default: semi_nxt = 5'd1;
              endcase
              acc_nxt  = '0;
              dig_nxt  = 1'b0;
              mode_nxt = MODE_LETTER;
            end
            default: ;
          endcase
        end
      end
      if (note_end) begin
        mode_nxt = MODE_IDLE;
        if (ec_r >= EcW'(MAX_EVENTS)) begin
          ovf_nxt  = 1'b1;
          kind_nxt = KIND_ERROR;
        end else begin
          ec_nxt   = ec_r + 1'b1;
          kind_nxt = rest_r ? KIND_REST : KIND_NOTE;
        end
      end
    end else if (seq_r == SEQ_OUT && res_load) begin
      // trailing character after a note, handled as idle text; end of string resets the parser state
      if (!eot_r && !ovf_r && !dot_r) begin
        case (c)
          8'h4f, 8'h4c, 8'h54, 8'h56: begin
            cmd_nxt  = (c == 8'h4f) ? CMD_O : (c == 8'h4c) ? CMD_L :
                       (c == 8'h54) ? CMD_T : CMD_V;
            acc_nxt  = '0;
            dig_nxt  = 1'b0;
            mode_nxt = MODE_CMD;
          end
          8'h3e: if (oct_r < 4'd8) oct_nxt = oct_r + 4'd1;
          8'h3c: if (oct_r > 4'd1) oct_nxt = oct_r - 4'd1;
          8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h52: begin
            rest_nxt = (c == 8'h52);
            case (c)
              8'h41:   semi_nxt = 5'd10;
              8'h42:   semi_nxt = 5'd12;
              8'h43:   semi_nxt = 5'd1;
              8'h44:   semi_nxt = 5'd3;
              8'h45:   semi_nxt = 5'd5;
              8'h46:   semi_nxt = 5'd6;
              8'h47:   semi_nxt = 5'd8;
              default: semi_nxt = 5'd1;
            endcase
            acc_nxt  = '0;
            dig_nxt  = 1'b0;
            mode_nxt = MODE_LETTER;
          end
          default: ;
        endcase
      end
      if (eot_r) begin
        mode_nxt = MODE_IDLE; cmd_nxt = CMD_O; oct_nxt = 4'd4; dlen_nxt = 7'd4;
        tempo_nxt = 8'd120; vol_nxt = dvol_r; semi_nxt = '0; rest_nxt = 1'b0;
        acc_nxt = '0; dig_nxt = 1'b0; ec_nxt = '0; ovf_nxt = 1'b0;
      end
    end
  end

  // note arithmetic operands
  always_comb begin
    len   = (dig_r && acc_r != 20'd0) ? acc_r : 20'(dlen_r);
    n7    = 7'(semi_r) + 7'(oct_r) * 7'd12 - 7'd1;
    // n/12 as n*43>>9, exact over the note range
    n_mul = 13'(n7) * 13'd43;
    n_q   = n_mul[12:9];
    n_idx = 4'(n7 - 7'(n_q) * 7'd12);
    n_oct = (n_q > 4'd9) ? 4'd9 : n_q;
    shamt = 5'd17 - 5'(n_oct);
    ftab  = freq_o9(n_idx);
    dur15 = 28'(dur_r) * 28'd15;
    // x/100 as x*ceil(2^27/100)>>27, exact below 2^20; larger values clamp
    gprod = 41'(dur15[19:0]) * 41'd1342178;
    gapq  = (dur15 >= 28'd1000000) ? 14'd10000 : gprod[40:27];
  end

  // sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SEQ_IDLE:  if (in_valid && in_ready) seq_nxt = SEQ_PARSE;
      SEQ_PARSE: begin
        if (note_end && !(ec_r >= EcW'(MAX_EVENTS))) seq_nxt = SEQ_MUL;
        else if (note_end || item_r.func) seq_nxt = SEQ_OUT;
        else seq_nxt = SEQ_IDLE;
      end
      SEQ_MUL:   seq_nxt = SEQ_DIV;
      SEQ_DIV:   if (drsp.done) seq_nxt = SEQ_GAP;
      SEQ_GAP:   seq_nxt = SEQ_OUT;
      SEQ_OUT:   if (res_load) seq_nxt = SEQ_IDLE;
      default:   seq_nxt = SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    prod_nxt = prod_r;
    dur_nxt  = dur_r;
    gap_nxt  = gap_r;
    frq_nxt  = frq_r;
    dreq.start    = 1'b0;
    dreq.dividend = dot_r ? DivBits'(360000000) : DivBits'(240000000);
    case (seq_r)
      SEQ_PARSE: begin
        prod_nxt = 28'(tempo_r) * 28'(len);
        frq_nxt  = 22'(ftab >> shamt);
        dur_nxt  = '0;
        gap_nxt  = '0;
      end
      SEQ_MUL: begin
        if (prod_r == 28'd0) prod_nxt = 28'd1;
        dreq.start = 1'b1;
      end
      SEQ_DIV: if (drsp.done) dur_nxt = drsp.quotient[23:0];
      SEQ_GAP: gap_nxt = gapq;
      default: ;
    endcase
    dreq.divisor = (prod_r == 28'd0) ? DivBits'(1) : DivBits'(prod_r);
  end

  // result assembly
  always_comb begin
    res_load = (seq_r == SEQ_OUT) && !ov_r;
    res_data = '0;
    res_data.end_of_track = eot_r;
    res_data.kind         = kind_r;
    if (kind_r == KIND_NOTE || kind_r == KIND_REST) begin
      res_data.frequency_q8 = (kind_r == KIND_REST) ? 22'd0 : frq_r;
      res_data.duration_us  = dur_r;
      res_data.gap_us       = (kind_r == KIND_REST) ? 14'd0 : gap_r;
      res_data.volume       = vol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_IDLE;  mode_r <= MODE_IDLE; cmd_r <= CMD_O; oct_r <= 4'd4;
      dlen_r <= 7'd4; tempo_r <= 8'd120; vol_r <= 4'd15; dvol_r <= 4'd15;
      semi_r <= '0; rest_r <= 1'b0; acc_r <= '0; dig_r <= 1'b0; ec_r <= '0;
      ovf_r <= 1'b0; ov_r <= 1'b0; dot_r <= 1'b0; eot_r <= 1'b0;
      kind_r <= KIND_END;
    end else begin
      seq_r <= seq_nxt; mode_r <= mode_nxt; cmd_r <= cmd_nxt; oct_r <= oct_nxt;
      dlen_r <= dlen_nxt; tempo_r <= tempo_nxt; vol_r <= vol_nxt;
      semi_r <= semi_nxt; rest_r <= rest_nxt; acc_r <= acc_nxt; dig_r <= dig_nxt;
      ec_r <= ec_nxt; ovf_r <= ovf_nxt; dot_r <= dot_nxt; eot_r <= eot_nxt;
      kind_r <= kind_nxt;
      if (cfg_we) dvol_r <= cfg_wdata;
      if (res_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (in_valid && in_ready) item_r <= in_data;
    prod_r <= prod_nxt; dur_r <= dur_nxt; gap_r <= gap_nxt; frq_r <= frq_nxt;
    if (res_load) ov_data_r <= res_data;
  end

  assign out_valid = ov_r;
  assign out_data  = ov_data_r;
endmodule
`default_nettype wire

>>> src/mml_div.sv
// Restoring divider, one quotient bit per cycle, used by the duration work.
// Depends on mml_pkg.
`default_nettype none
module mml_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mml_pkg::mml_div_req_t req,
  output mml_pkg::mml_div_rsp_t      rsp
);
  import mml_pkg::*;

  localparam int CntW = $clog2(DivBits + 1);

  logic [DivBits-1:0] quo_r, quo_nxt;
  logic [DivBits-1:0] rem_r, rem_nxt;
  logic [DivBits-1:0] dsr_r, dsr_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivBits-1:0] trial;
  logic [DivBits:0]   diff;

  // one shift-subtract step per cycle; remainder stays below the divisor
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DivBits-2:0], quo_r[DivBits-1]};
    diff     = {1'b0, trial} - {1'b0, dsr_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = CntW'(DivBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DivBits]) begin
        rem_nxt = diff[DivBits-1:0];
        quo_nxt = {quo_r[DivBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DivBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

>>> bench/tb_mml_note_event_parser.sv
// Testbench for the MML note event parser: drives characters and end-of-string
// transactions, predicts every note, rest, error and end event and checks them.
// Depends on mml_pkg and the mml_note_event_parser RTL.
`timescale 1ns / 100ps

class mml_event_board;
  mml_pkg::mml_out_t pending_events[$];
  int unsigned       fail_count;

  // parser state
  logic [3:0]  def_vol;
  logic [1:0]  mode;
  logic [1:0]  cmd;
  int unsigned oct, dlen, tempo, vol, semi, acc, evcnt;
  bit          is_rest, seen, ovf;

  function void init_all();
    def_vol    = 4'd15;
    fail_count = 0;
    restart();
  endfunction

  function void restart();
    mode    = mml_pkg::MODE_IDLE;
    cmd     = mml_pkg::CMD_O;
    oct     = 4;
    dlen    = 4;
    tempo   = 120;
    vol     = def_vol;
    semi    = 0;
    is_rest = 0;
    acc     = 0;
    seen    = 0;
    evcnt   = 0;
    ovf     = 0;
  endfunction

  function void push_event(logic [1:0] k, int unsigned f, int unsigned d,
                           int unsigned g, int unsigned v, bit eot);
    mml_pkg::mml_out_t e;
    e.kind = k;
    e.frequency_q8 = f[21:0];
    e.duration_us = d[23:0];
    e.gap_us = g[13:0];
    e.volume = v[3:0];
    e.end_of_track = eot;
    pending_events.push_back(e);
  endfunction

  function void digit(int unsigned c);
    if (acc < mml_pkg::NumLimit) acc = acc * 10 + (c - 48);
    seen = 1;
  endfunction

  function void apply_cmd();
    mode = mml_pkg::MODE_IDLE;
    if (!seen) return;
    case (cmd)
      mml_pkg::CMD_O: if (acc >= 1 && acc <= 8) oct = acc;
      mml_pkg::CMD_L: if (acc >= 1 && acc <= 64) dlen = acc;
      mml_pkg::CMD_T: if (acc >= 32 && acc <= 255) tempo = acc;
      default: vol = (acc > 15) ? 15 : acc;
    endcase
  endfunction

  function void close_note(bit dotted, bit eot);
    longint unsigned prod, dur;
    int unsigned     len, n, o, f, g;
    mode = mml_pkg::MODE_IDLE;
    if (evcnt >= mml_pkg::MaxEventsDef) begin
      ovf = 1;
      push_event(mml_pkg::KIND_ERROR, 0, 0, 0, 0, eot);
      return;
    end
    evcnt++;
    len  = (seen && acc != 0) ? acc : dlen;
    prod = longint'(tempo) * len;
    if (prod == 0) prod = 1;
    dur  = (dotted ? 64'd360000000 : 64'd240000000) / prod;
    f = 0;
    g = 0;
    if (!is_rest) begin
      n = semi + 12 * oct - 1;
      o = n / 12;
      if (o > 9) o = 9;
      f = mml_pkg::freq_o9(4'(n % 12)) >> (17 - o);
      g = 32'((dur * 15) / 100);
      if (g > 10000) g = 10000;
    end
    push_event(is_rest ? mml_pkg::KIND_REST : mml_pkg::KIND_NOTE, f, 32'(dur), g, vol, eot);
  endfunction

  function void idle_char(int unsigned c);
    if (c >= 97 && c <= 122) c -= 32;
    case (c)
      "O", "L", "T", "V": begin
        cmd  = (c == "O") ? mml_pkg::CMD_O : (c == "L") ? mml_pkg::CMD_L :
               (c == "T") ? mml_pkg::CMD_T : mml_pkg::CMD_V;
        acc  = 0;
        seen = 0;
        mode = mml_pkg::MODE_CMD;
      end
      ">": if (oct < 8) oct++;
      "<": if (oct > 1) oct--;
      "A", "B", "C", "D", "E", "F", "G", "R": begin
        is_rest = (c == "R");
        case (c)
          "A": semi = 10;
          "B": semi = 12;
          "C": semi = 1;
          "D": semi = 3;
          "E": semi = 5;
          "F": semi = 6;
          "G": semi = 8;
          default: semi = 1;
        endcase
        acc  = 0;
        seen = 0;
        mode = mml_pkg::MODE_LETTER;
      end
      default: ;
    endcase
  endfunction

  // note one accepted input transaction
  function void note_input(mml_pkg::mml_in_t t);
    int unsigned c;
    bit          dig;
    c   = t.ch;
    dig = (c >= 48 && c <= 57);
    if (t.func) begin
      if (!ovf && (mode == mml_pkg::MODE_LETTER || mode == mml_pkg::MODE_LEN))
        close_note(0, 1);
      else begin
        if (!ovf && mode == mml_pkg::MODE_CMD) apply_cmd();
        push_event(mml_pkg::KIND_END, 0, 0, 0, 0, 1);
      end
      restart();
      return;
    end
    if (ovf) return;
    case (mode)
      mml_pkg::MODE_CMD: begin
        if (dig) digit(c);
        else begin
          apply_cmd();
          idle_char(c);
        end
      end
      mml_pkg::MODE_LETTER, mml_pkg::MODE_LEN: begin
        if (mode == mml_pkg::MODE_LETTER && !is_rest && (c == "#" || c == "+" || c == "-")) begin
          semi = (c == "-") ? semi - 1 : semi + 1;
          mode = mml_pkg::MODE_LEN;
        end else if (dig) begin
          digit(c);
          mode = mml_pkg::MODE_LEN;
        end else if (c == ".") close_note(1, 0);
        else begin
          close_note(0, 0);
          if (!ovf) idle_char(c);
        end
      end
      default: idle_char(c);
    endcase
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    fail_count++;
  endtask

  // compare one accepted result with the oldest predicted event
  task check_event(mml_pkg::mml_out_t got);
    mml_pkg::mml_out_t want;
    if (pending_events.size() == 0) begin
      report($sformatf("unexpected event %h", got));
      return;
    end
    want = pending_events.pop_front();
    if (got.kind != want.kind)
      report($sformatf("kind %0d want %0d", got.kind, want.kind));
    if (got.frequency_q8 != want.frequency_q8)
      report($sformatf("freq %0d want %0d", got.frequency_q8, want.frequency_q8));
    if (got.duration_us != want.duration_us)
      report($sformatf("duration %0d want %0d", got.duration_us, want.duration_us));
    if (got.gap_us != want.gap_us)
      report($sformatf("gap %0d want %0d", got.gap_us, want.gap_us));
    if (got.volume != want.volume)
      report($sformatf("volume %0d want %0d", got.volume, want.volume));
    if (got.end_of_track != want.end_of_track)
      report($sformatf("eot %0d want %0d", got.end_of_track, want.end_of_track));
  endtask
endclass

module tb_mml_note_event_parser;
  localparam int WatchLimit = 20000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_ready;
  mml_pkg::mml_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 0;
  mml_pkg::mml_out_t out_data;
  logic              cfg_we = 0;
  logic [3:0]        cfg_wdata = '0;

  mml_event_board board;
  bit             stall_go = 0;
  bit             hold = 0;
  bit             out_took = 0;
  int unsigned    rx_wait = 0;
  int unsigned    idle_cycles = 0;

  mml_note_event_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // offer one transaction, with a random gap first
  task send(bit f, logic [7:0] c);
    repeat ($urandom_range(0, 8)) @(negedge clk);
    in_data.func = f;
    in_data.ch   = c;
    in_valid     = 1;
    do @(posedge clk); while (!in_ready);
    board.note_input(in_data);
    @(negedge clk);
    in_valid = 0;
  endtask

  task send_text(string s);
    for (int i = 0; i < s.len(); i++) send(0, s[i]);
  endtask

  // wait for all events out, let the block settle, then write the volume
  task set_volume(logic [3:0] v);
    while (board.pending_events.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1;
    @(negedge clk);
    cfg_we = 0;
    board.def_vol = v;
  endtask

  function logic [7:0] pick_char();
    string alpha;
    alpha = "abcdefgrABCDEFGRoltvOLTV<>#+-.0123456789 ";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(48, 57));
      default: return alpha[$urandom_range(0, alpha.len() - 1)];
    endcase
  endfunction

  // long hold-off on the result side, counted here
  initial begin
    wait (stall_go);
    hold = 1;
    repeat (400) @(negedge clk);
    hold = 0;
  end

  // result side: a random wait after each accepted transaction before out_ready rises again
  always @(negedge clk) begin
    if (out_took) rx_wait = $urandom_range(0, 8);
    if (!rst_n) out_ready <= 0;
    else if (hold) out_ready <= 0;
    else if (rx_wait != 0) begin
      rx_wait--;
      out_ready <= 0;
    end else out_ready <= 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_event(out_data);
    out_took <= rst_n && out_valid && out_ready;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    board = new();
    board.init_all();
    repeat (12) @(negedge clk);
    rst_n = 1;

    // directed: extremes, commands, accidentals, dots, saturation, zero byte
    send_text("o8b#4.v99 l64c o1c-1 t255a t32g l0r#");
    send(1, 8'hff);
    set_volume(4'd0);
    send_text(">>>>>>>>>c<<<<<<<<<c2 o9l65t31 rR4.");
    send(0, 8'h00);
    send_text("d99999999e0v");
    send(1, 8'h00);
    send(1, 8'h41);
    set_volume(4'd15);

    // long stall on the result side while input keeps coming
    stall_go = 1;
    send_text("cdefgab>cdefgab");
    send(1, 0);

    // overflow: more than the event limit in one string
    for (int i = 0; i < 260; i++) send(0, (i % 2) ? "c" : "r");
    send_text("v3d");
    send(1, 0);

    for (int p = 0; p < 4; p++) begin
      set_volume(p == 3 ? 4'd15 : 4'($urandom_range(0, 15)));
      for (int i = 0; i < 300; i++) begin
        if ($urandom_range(0, 40) == 0) send(1, 8'($urandom_range(0, 255)));
        else send(0, pick_char());
      end
      send(1, 0);
    end

    while (board.pending_events.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (board.fail_count == 0 && board.pending_events.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
